/* rtl/sas_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_pkg: shared constants for the steering agent step block
// field widths, register reset values and item kind codes
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int VW       = 24;  // position / velocity width
  localparam int CFG_DW   = 20;  // widest configuration register
  localparam int CFG_AW   = 3;   // configuration index width

  localparam int FRACTION_BITS_DEF = 8;

  localparam logic [15:0] MAX_SPEED_RST     = 16'd1280;
  localparam logic [15:0] MAX_FORCE_RST     = 16'd51;
  localparam logic [19:0] ARRIVE_RADIUS_RST = 20'd25600;
  localparam logic [14:0] FIELD_WIDTH_RST   = 15'd1024;
  localparam logic [14:0] FIELD_HEIGHT_RST  = 15'd768;

  localparam logic [CFG_AW-1:0] REG_MAX_SPEED     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_MAX_FORCE     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_ARRIVE_RADIUS = 3'd2;
  localparam logic [CFG_AW-1:0] REG_FIELD_WIDTH   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_FIELD_HEIGHT  = 3'd4;

  localparam logic [1:0] KIND_PLACE  = 2'd0;
  localparam logic [1:0] KIND_STEP   = 2'd1;
  localparam logic [1:0] KIND_SEEK   = 2'd2;
  localparam logic [1:0] KIND_ARRIVE = 2'd3;

  // saturate a 27 bit signed sum to the 24 bit range
  function automatic logic [VW-1:0] sat24(input logic signed [26:0] v);
    logic [VW-1:0] res;
    if (v > 27'sd8388607) begin
      res = 24'h7fffff;
    end else if (v < -27'sd8388608) begin
      res = 24'h800000;
    end else begin
      res = v[VW-1:0];
    end
    return res;
  endfunction

endpackage

/* rtl/steering_agent_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// steering_agent_step_top: seek / arrive steering of one point agent
// one shared multiplier and one shared compare-subtract unit (square root and
// division) under a small sequencer
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_stall  | kind, target x/y, force x/y
// out     | output    | out_valid / out_stall| position x/y, velocity x/y
// cfg     | input     | cfg_we               | cfg_addr, cfg_wdata
//
// a place item goes straight to the result; a step item runs vector length
// passes, each of squaring and, where needed, 25 square root steps and two
// divisions, all on the one compare-subtract unit
// seek and arrive items run three such passes, a plain step one
// in_stall is high from acceptance until the result item is taken
// synchronous active low reset restores the register defaults and a zero agent
// ----------------------------------------------------------------------------
module steering_agent_step_top
  import sas_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic signed [VW-1:0]     in_target_x,
  input  logic signed [VW-1:0]     in_target_y,
  input  logic signed [VW-1:0]     in_force_x,
  input  logic signed [VW-1:0]     in_force_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VW-1:0]     out_pos_x_out,
  output logic signed [VW-1:0]     out_pos_y_out,
  output logic signed [VW-1:0]     out_vel_x_out,
  output logic signed [VW-1:0]     out_vel_y_out,
  input  logic                     cfg_we,
  input  logic [CFG_AW-1:0]        cfg_addr,
  input  logic [CFG_DW-1:0]        cfg_wdata
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SQ1    = 4'd1;
  localparam logic [3:0] ST_SQ2    = 4'd2;
  localparam logic [3:0] ST_SQ3    = 4'd3;
  localparam logic [3:0] ST_CMP    = 4'd4;
  localparam logic [3:0] ST_SQRT   = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_DIV    = 4'd7;
  localparam logic [3:0] ST_PDONE  = 4'd8;
  localparam logic [3:0] ST_BOUNCE = 4'd9;
  localparam logic [3:0] ST_ACCEL  = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  localparam logic [1:0] PH_SEEK  = 2'd0;
  localparam logic [1:0] PH_STEER = 2'd1;
  localparam logic [1:0] PH_VEL   = 2'd2;

  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 16;

  logic [3:0]  state_r;
  logic [1:0]  phase_r;
  logic [1:0]  kind_r;
  logic        comp_r;
  logic [4:0]  cnt_r;

  logic [15:0] max_speed_r;
  logic [15:0] max_force_r;
  logic [19:0] arrive_radius_r;
  logic [14:0] field_width_r;
  logic [14:0] field_height_r;

  logic signed [VW-1:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r;
  logic signed [VW-1:0] frc_x_r, frc_y_r;
  logic signed [24:0]   wx_r, wy_r;
  logic signed [25:0]   acc_x_r, acc_y_r;
  logic [15:0]          num_r;
  logic [24:0]          den_r;
  logic [49:0]          prod_r, sum_r, op_r;
  logic [26:0]          rem_r;
  logic [15:0]          q_r;

  // shared multiplier
  logic [24:0] mul_a, mul_b;
  logic [49:0] mul_p;
  logic signed [24:0] w_sel;
  logic [24:0] abs_wx, abs_wy, abs_sel;

  assign abs_wx  = wx_r[24] ? 25'(-wx_r) : 25'(wx_r);
  assign abs_wy  = wy_r[24] ? 25'(-wy_r) : 25'(wy_r);
  assign w_sel   = comp_r ? wy_r : wx_r;
  assign abs_sel = comp_r ? abs_wy : abs_wx;

  logic [24:0] lim_sel;
  always_comb begin
    case (phase_r)
      PH_SEEK:  lim_sel = {5'd0, arrive_radius_r};
      PH_STEER: lim_sel = {9'd0, max_force_r};
      default:  lim_sel = {9'd0, max_speed_r};
    endcase
  end

  always_comb begin
    case (state_r)
      ST_SQ1:  begin mul_a = abs_wx;  mul_b = abs_wx;           end
      ST_SQ2:  begin mul_a = abs_wy;  mul_b = abs_wy;           end
      ST_SQ3:  begin mul_a = lim_sel; mul_b = lim_sel;          end
      default: begin mul_a = abs_sel; mul_b = {9'd0, num_r};    end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // compare-subtract unit, square root step or division step
  logic [26:0] sq_sh, sq_trial, dv_t, cs_a, cs_b, cs_diff;
  logic        cs_ge;
  assign sq_sh    = {rem_r[24:0], op_r[49:48]};
  assign sq_trial = {den_r, 2'b01};
  assign dv_t     = {1'b0, rem_r[24:0], q_r[15]};
  assign cs_a     = (state_r == ST_SQRT) ? sq_sh : dv_t;
  assign cs_b     = (state_r == ST_SQRT) ? sq_trial : {2'b00, den_r};
  assign cs_ge    = cs_a >= cs_b;
  assign cs_diff  = cs_a - cs_b;

  // signed quotient of the division just finishing
  logic [15:0] q_fin;
  logic signed [24:0] q_signed;
  assign q_fin    = {q_r[14:0], cs_ge};
  assign q_signed = w_sel[24] ? -$signed({9'd0, q_fin}) : $signed({9'd0, q_fin});

  // field bounds test on the position before the update
  logic signed [47:0] fw_lim, fh_lim, px_ext, py_ext;
  logic               out_x, out_y;
  assign fw_lim = $signed(48'(field_width_r) << FRACTION_BITS);
  assign fh_lim = $signed(48'(field_height_r) << FRACTION_BITS);
  assign px_ext = 48'(pos_x_r);
  assign py_ext = 48'(pos_y_r);
  assign out_x  = pos_x_r[VW-1] || (px_ext > fw_lim);
  assign out_y  = pos_y_r[VW-1] || (py_ext > fh_lim);

  logic [VW-1:0] vx_acc, vy_acc;
  assign vx_acc = sat24(27'(vel_x_r) + 27'(acc_x_r));
  assign vy_acc = sat24(27'(vel_y_r) + 27'(acc_y_r));

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = (state_r == ST_OUT);
  assign out_pos_x_out = pos_x_r;
  assign out_pos_y_out = pos_y_r;
  assign out_vel_x_out = vel_x_r;
  assign out_vel_y_out = vel_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      phase_r         <= PH_SEEK;
      comp_r          <= 1'b0;
      cnt_r           <= '0;
      max_speed_r     <= MAX_SPEED_RST;
      max_force_r     <= MAX_FORCE_RST;
      arrive_radius_r <= ARRIVE_RADIUS_RST;
      field_width_r   <= FIELD_WIDTH_RST;
      field_height_r  <= FIELD_HEIGHT_RST;
      pos_x_r         <= '0;
      pos_y_r         <= '0;
      vel_x_r         <= '0;
      vel_y_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MAX_SPEED:     max_speed_r     <= cfg_wdata[15:0];
          REG_MAX_FORCE:     max_force_r     <= cfg_wdata[15:0];
          REG_ARRIVE_RADIUS: arrive_radius_r <= cfg_wdata;
          REG_FIELD_WIDTH:   field_width_r   <= cfg_wdata[14:0];
          REG_FIELD_HEIGHT:  field_height_r  <= cfg_wdata[14:0];
          default: ;
        endcase
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r  <= in_kind;
            frc_x_r <= in_force_x;
            frc_y_r <= in_force_y;
            if (in_kind == KIND_PLACE) begin
              pos_x_r <= in_target_x;
              pos_y_r <= in_target_y;
              vel_x_r <= in_force_x;
              vel_y_r <= in_force_y;
              state_r <= ST_OUT;
            end else if (in_kind == KIND_STEP) begin
              acc_x_r <= 26'(in_force_x);
              acc_y_r <= 26'(in_force_y);
              state_r <= ST_BOUNCE;
            end else begin
              wx_r    <= 25'(in_target_x) - 25'(pos_x_r);
              wy_r    <= 25'(in_target_y) - 25'(pos_y_r);
              phase_r <= PH_SEEK;
              state_r <= ST_SQ1;
            end
          end
        end
        ST_SQ1: begin
          prod_r  <= mul_p;
          state_r <= ST_SQ2;
        end
        ST_SQ2: begin
          sum_r   <= prod_r;
          prod_r  <= mul_p;
          state_r <= ST_SQ3;
        end
        ST_SQ3: begin
          sum_r   <= sum_r + prod_r;
          prod_r  <= mul_p;
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          comp_r <= 1'b0;
          cnt_r  <= '0;
          op_r   <= sum_r;
          rem_r  <= '0;
          if (phase_r == PH_SEEK) begin
            num_r <= max_speed_r;
            if (kind_r == KIND_ARRIVE && sum_r < prod_r) begin
              // inside the radius: speed falls off linearly
              den_r   <= {5'd0, arrive_radius_r};
              state_r <= ST_MUL;
            end else if (sum_r != '0) begin
              den_r   <= '0;
              state_r <= ST_SQRT;
            end else begin
              wx_r    <= '0;
              wy_r    <= '0;
              state_r <= ST_PDONE;
            end
          end else begin
            num_r <= lim_sel[15:0];
            den_r <= '0;
            if (sum_r > prod_r) begin
              state_r <= ST_SQRT;
            end else begin
              state_r <= ST_PDONE;
            end
          end
        end
        ST_SQRT: begin
          op_r  <= {op_r[47:0], 2'b00};
          rem_r <= cs_ge ? cs_diff : sq_sh;
          den_r <= {den_r[23:0], cs_ge};
          if (cnt_r == 5'(SQRT_STEPS - 1)) begin
            state_r <= ST_MUL;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_MUL: begin
          // quotient fits 16 bits, so the top of the product is below den
          rem_r   <= {2'b00, mul_p[40:16]};
          q_r     <= mul_p[15:0];
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r <= {2'b00, cs_ge ? cs_diff[24:0] : dv_t[24:0]};
          q_r   <= q_fin;
          if (cnt_r == 5'(DIV_STEPS - 1)) begin
            if (comp_r) begin
              wy_r    <= q_signed;
              state_r <= ST_PDONE;
            end else begin
              wx_r    <= q_signed;
              comp_r  <= 1'b1;
              state_r <= ST_MUL;
            end
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_PDONE: begin
          case (phase_r)
            PH_SEEK: begin
              wx_r    <= wx_r - 25'(vel_x_r);
              wy_r    <= wy_r - 25'(vel_y_r);
              phase_r <= PH_STEER;
              state_r <= ST_SQ1;
            end
            PH_STEER: begin
              acc_x_r <= 26'(frc_x_r) + 26'(wx_r);
              acc_y_r <= 26'(frc_y_r) + 26'(wy_r);
              state_r <= ST_BOUNCE;
            end
            default: begin
              vel_x_r <= wx_r[VW-1:0];
              vel_y_r <= wy_r[VW-1:0];
              pos_x_r <= sat24(27'(pos_x_r) + 27'(wx_r));
              pos_y_r <= sat24(27'(pos_y_r) + 27'(wy_r));
              state_r <= ST_OUT;
            end
          endcase
        end
        ST_BOUNCE: begin
          if (out_x) vel_x_r <= sat24(-27'(vel_x_r));
          if (out_y) vel_y_r <= sat24(-27'(vel_y_r));
          state_r <= ST_ACCEL;
        end
        ST_ACCEL: begin
          vel_x_r <= vx_acc;
          vel_y_r <= vy_acc;
          wx_r    <= 25'($signed(vx_acc));
          wy_r    <= 25'($signed(vy_acc));
          phase_r <= PH_VEL;
          state_r <= ST_SQ1;
        end
        ST_OUT: begin
          if (!out_stall) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* test/sas_step_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sas_step_checker: result predictor and scoreboard for the steering agent
// follows register writes and accepted input items, works out the expected
// position and velocity of the agent and compares every result item
// ----------------------------------------------------------------------------
module sas_step_checker
  import sas_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [1:0]           in_kind,
  input  logic signed [VW-1:0] in_target_x,
  input  logic signed [VW-1:0] in_target_y,
  input  logic signed [VW-1:0] in_force_x,
  input  logic signed [VW-1:0] in_force_y,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic signed [VW-1:0] out_pos_x_out,
  input  logic signed [VW-1:0] out_pos_y_out,
  input  logic signed [VW-1:0] out_vel_x_out,
  input  logic signed [VW-1:0] out_vel_y_out,
  input  logic                 cfg_we,
  input  logic [CFG_AW-1:0]    cfg_addr,
  input  logic [CFG_DW-1:0]    cfg_wdata,
  output int                   mismatches,
  output int                   pending
);

  typedef struct {
    logic signed [VW-1:0] px;
    logic signed [VW-1:0] py;
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
  } agent_t;

  localparam longint VEL_MAX = 64'sd8388607;
  localparam longint VEL_MIN = -64'sd8388608;

  agent_t agent_q[$];
  longint unsigned speed_lim, force_lim, slow_radius, field_w, field_h;
  longint pos_x, pos_y, vel_x, vel_y;
  int bad_cnt;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_sq(longint x, longint y);
    longint unsigned ax = (x < 0) ? -x : x;
    longint unsigned ay = (y < 0) ? -y : y;
    return ax * ax + ay * ay;
  endfunction

  function automatic longint clip(longint v);
    if (v > VEL_MAX) return VEL_MAX;
    if (v < VEL_MIN) return VEL_MIN;
    return v;
  endfunction

  // exact product then quotient, truncating toward zero
  function automatic longint rescale(longint a, longint unsigned num, longint unsigned den);
    return (a * longint'(num)) / longint'(den);
  endfunction

  task automatic cap_length(inout longint x, inout longint y, input longint unsigned lim);
    longint unsigned s;
    longint unsigned len;
    s = mag_sq(x, y);
    if (s > lim * lim) begin
      len = root_floor(s);
      x = rescale(x, lim, len);
      y = rescale(y, lim, len);
    end
  endtask

  task automatic advance_agent(input logic [1:0] kind, input longint tx, input longint ty,
                               input longint fx, input longint fy);
    longint ax, ay, dx, dy, wx, wy, sx, sy;
    longint unsigned s, len;
    longint one;
    one = longint'(1) << FRACTION_BITS;
    if (kind == KIND_PLACE) begin
      pos_x = tx; pos_y = ty; vel_x = fx; vel_y = fy;
    end else begin
      ax = fx; ay = fy;
      if (kind == KIND_SEEK || kind == KIND_ARRIVE) begin
        dx = tx - pos_x; dy = ty - pos_y;
        wx = 0; wy = 0;
        s = mag_sq(dx, dy);
        if (kind == KIND_ARRIVE && s < slow_radius * slow_radius) begin
          wx = rescale(dx, speed_lim, slow_radius);
          wy = rescale(dy, speed_lim, slow_radius);
        end else if (s != 0) begin
          len = root_floor(s);
          wx = rescale(dx, speed_lim, len);
          wy = rescale(dy, speed_lim, len);
        end
        sx = wx - vel_x; sy = wy - vel_y;
        cap_length(sx, sy, force_lim);
        ax += sx; ay += sy;
      end
      // bounce test uses the position before the update
      if (pos_x < 0 || pos_x > longint'(field_w) * one) vel_x = clip(-vel_x);
      if (pos_y < 0 || pos_y > longint'(field_h) * one) vel_y = clip(-vel_y);
      vel_x = clip(vel_x + ax);
      vel_y = clip(vel_y + ay);
      cap_length(vel_x, vel_y, speed_lim);
      pos_x = clip(pos_x + vel_x);
      pos_y = clip(pos_y + vel_y);
    end
  endtask

  task automatic compare_field(string name, logic signed [VW-1:0] exp_v,
                               logic signed [VW-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      bad_cnt++;
    end
  endtask

  always @(posedge clk) begin
    agent_t a;
    if (!rst_n) begin
      speed_lim = 64'(MAX_SPEED_RST);
      force_lim = 64'(MAX_FORCE_RST);
      slow_radius = 64'(ARRIVE_RADIUS_RST);
      field_w = 64'(FIELD_WIDTH_RST);
      field_h = 64'(FIELD_HEIGHT_RST);
      pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0;
      agent_q.delete();
      bad_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MAX_SPEED:     speed_lim = 64'(cfg_wdata[15:0]);
          REG_MAX_FORCE:     force_lim = 64'(cfg_wdata[15:0]);
          REG_ARRIVE_RADIUS: slow_radius = 64'(cfg_wdata[19:0]);
          REG_FIELD_WIDTH:   field_w = 64'(cfg_wdata[14:0]);
          REG_FIELD_HEIGHT:  field_h = 64'(cfg_wdata[14:0]);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (agent_q.size() == 0) begin
          $error("result item with no expectation waiting");
          bad_cnt++;
        end else begin
          a = agent_q.pop_front();
          compare_field("pos_x_out", a.px, out_pos_x_out);
          compare_field("pos_y_out", a.py, out_pos_y_out);
          compare_field("vel_x_out", a.vx, out_vel_x_out);
          compare_field("vel_y_out", a.vy, out_vel_y_out);
        end
      end
      if (in_valid && !in_stall) begin
        advance_agent(in_kind, in_target_x, in_target_y, in_force_x, in_force_y);
        a.px = VW'(pos_x); a.py = VW'(pos_y); a.vx = VW'(vel_x); a.vy = VW'(vel_y);
        agent_q.push_back(a);
      end
    end
    mismatches <= bad_cnt;
    pending <= agent_q.size();
  end

endmodule

/* test/tb_steering_agent_step_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_steering_agent_step_top: testbench for the steering agent step block
// directed corner items, then place / step sequences with random content
// under several register settings and idling patterns; a separate checker
// predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_steering_agent_step_top;
  import sas_pkg::*;

  localparam int  N_PHASES   = 10;
  localparam int  PHASE_ITEMS = 125;
  localparam int  HOLD_CYCLES = 400;
  localparam int  DRAIN_CYCLES = 250;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [CFG_AW-1:0] REG_SPARE = 3'd5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = KIND_PLACE;
  logic signed [VW-1:0] in_target_x = '0, in_target_y = '0;
  logic signed [VW-1:0] in_force_x = '0, in_force_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VW-1:0] out_pos_x_out, out_pos_y_out, out_vel_x_out, out_vel_y_out;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = REG_MAX_SPEED;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  int mismatches, pending;
  int send_pct = 0, stall_pct = 0;
  int hold_req = 0, hold_seen = 0, hold_left = 0;
  int item_cnt = 0, setting_cnt = 0;
  int cur_fw = FIELD_WIDTH_RST, cur_fh = FIELD_HEIGHT_RST;
  longint cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  steering_agent_step_top u_dut (.*);

  sas_step_checker u_chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_item(logic [1:0] kind, int tx, int ty, int fx, int fy);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_target_x <= VW'(tx);
    in_target_y <= VW'(ty);
    in_force_x <= VW'(fx);
    in_force_y <= VW'(fy);
    do @(posedge clk); while (in_stall);
    item_cnt++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(int spd, int frc, int rad, int fw, int fh);
    int vals[5];
    vals = '{spd, frc, rad, fw, fh};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_addr <= REG_MAX_SPEED + CFG_AW'(i);
      cfg_wdata <= CFG_DW'(vals[i]);
      @(posedge clk);
    end
    // writes beyond the register list must be ignored
    cfg_addr <= REG_SPARE + CFG_AW'($urandom_range(2));
    cfg_wdata <= CFG_DW'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_fw = fw & 16'h7fff;
    cur_fh = fh & 16'h7fff;
    setting_cnt++;
  endtask

  function automatic int near(int base, int spread);
    return base + int'($urandom_range(2 * spread)) - spread;
  endfunction

  function automatic logic [1:0] step_kind();
    case ($urandom_range(2))
      0: return KIND_STEP;
      1: return KIND_SEEK;
      default: return KIND_ARRIVE;
    endcase
  endfunction

  // a place item then a run of steps; a minority of items are pure noise
  task automatic random_sequence(inout int left);
    int px, py, n;
    if ($urandom_range(99) < 15) begin
      send_item(2'($urandom), $urandom, $urandom, $urandom, $urandom);
      left--;
      return;
    end
    px = $urandom_range(cur_fw * 256);
    py = $urandom_range(cur_fh * 256);
    if ($urandom_range(9) == 0) px = near(0, 2000);
    send_item(KIND_PLACE, px, py, near(0, 1500), near(0, 1500));
    left--;
    n = $urandom_range(2, 12);
    while (n > 0 && left > 0) begin
      if ($urandom_range(9) == 0)
        send_item(step_kind(), $urandom, $urandom, $urandom, $urandom);
      else
        send_item(step_kind(), near(px, 30000), near(py, 30000), near(0, 80), near(0, 80));
      n--;
      left--;
    end
  endtask

  initial begin
    int left;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners under the reset register values
    send_item(KIND_STEP, 0, 0, 0, 0);
    send_item(KIND_PLACE, 100 * 256, 100 * 256, 0, 0);
    send_item(KIND_SEEK, 600 * 256, 300 * 256, 0, 0);
    send_item(KIND_ARRIVE, 150 * 256, 120 * 256, 0, 0);
    send_item(KIND_PLACE, 200 * 256, 200 * 256, 300, -300);
    send_item(KIND_ARRIVE, 200 * 256, 200 * 256, 0, 0);  // target on the agent
    send_item(KIND_SEEK, 200 * 256, 200 * 256, 5, -5);
    send_item(KIND_STEP, 0, 0, 24'h7fffff, 24'h800000);
    send_item(KIND_PLACE, -256, 2000 * 256, 24'h800000, 24'h800000);  // outside field
    send_item(KIND_STEP, 0, 0, 0, 0);
    send_item(KIND_PLACE, 24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000);
    send_item(KIND_SEEK, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_item(KIND_ARRIVE, 24'h7fffff, 24'h800000, 24'h800000, 24'h800000);
    send_item(KIND_PLACE, 1024 * 256, 768 * 256, 100, 100);  // on the edge
    send_item(KIND_STEP, 0, 0, 0, 0);
    wait_idle();

    // register extremes, with zero radius making arrive act as seek
    set_regs(0, 0, 0, 0, 0);
    send_item(KIND_PLACE, 10 * 256, 10 * 256, 500, 500);
    send_item(KIND_ARRIVE, 11 * 256, 10 * 256, 0, 0);
    send_item(KIND_SEEK, 0, 0, 7, 7);
    wait_idle();
    set_regs(65535, 65535, 1048575, 32767, 32767);
    send_item(KIND_PLACE, 100, 100, 0, 0);
    send_item(KIND_ARRIVE, 24'h7fffff, 24'h7fffff, 0, 0);
    send_item(KIND_SEEK, 24'h800000, 24'h800000, 0, 0);
    send_item(KIND_STEP, 0, 0, 24'h7fffff, 24'h7fffff);
    wait_idle();

    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 46; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 46; end
        default: begin send_pct = 10; stall_pct = 10; end
      endcase
      case (p)
        0: set_regs(MAX_SPEED_RST, MAX_FORCE_RST, ARRIVE_RADIUS_RST,
                    FIELD_WIDTH_RST, FIELD_HEIGHT_RST);
        1: set_regs(65535, 65535, 1048575, 32767, 32767);
        2: set_regs(0, 0, 1, 1, 1);
        3: set_regs($urandom, $urandom, $urandom, $urandom, $urandom);
        default: set_regs($urandom_range(4096), $urandom_range(512),
                          $urandom_range(1, 60000), $urandom_range(1, 4000),
                          $urandom_range(1, 4000));
      endcase
      if (p == 4) hold_req++;
      left = PHASE_ITEMS;
      while (left > 0) random_sequence(left);
      // sender pauses here until every result item has been taken
      wait_idle();
    end

    send_pct = 0;
    stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d input items over %0d register settings,", item_cnt, setting_cnt);
    $display("four idling patterns and one long receiver hold-off");
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending != 0) $error("%0d expected result items never arrived", pending);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sas_pkg.sv
rtl/steering_agent_step_top.sv
test/sas_step_checker.sv
test/tb_steering_agent_step_top.sv
